FILE: sv/plq_pkg.sv
// shared types and constants for the positional list queue
`timescale 1ns / 1ps
package plq_pkg;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 8;
    localparam int ENTRY_W = 5;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_OOB   = 2'd2,
        ST_FULL  = 2'd3
    } plq_status_t;

    // one shift step broadcast to every cell of the row
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [POS_W-1:0]  at;
        logic [DATA_W-1:0] val;
    } plq_ctl_t;

endpackage

FILE: sv/positional_list_queue.sv
// positional list queue: ordered list with insert and remove at a 1-based position
// a result is registered in the output slot as its request beat is accepted
// throughput: one request per cycle while the slot is free; each insert or remove is one shift step of the cell row
// the input takes a new beat while a finished result waits, as long as m_tready frees the slot
// reset clears the length and the output valid; list words are not reset
`timescale 1ns / 1ps
module positional_list_queue #(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position [7:0], push_value [39:8]
    input  logic        s_tuser,   // req_type [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // popped_value [31:0], status [33:32], entry_count [38:34]
);
    import plq_pkg::*;

    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int CMP_W = POS_W + 1;

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [39:0]      m_data_reg;
    logic [39:0]      m_data_next;

    logic              s_fire;
    logic              req_type;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] push_value;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  len_ext;
    logic              is_empty;
    logic              is_full;
    plq_ctl_t          ctl;
    plq_status_t       status;
    logic [DATA_W-1:0] popped_value;

    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] cell_hit  [DEPTH];
    logic [DATA_W-1:0] hit_or;

    assign s_fire     = s_tvalid && s_tready;
    assign s_tready   = !m_valid_reg || m_tready;
    assign req_type   = s_tuser;
    assign position   = s_tdata[7:0];
    assign push_value = s_tdata[39:8];
    assign pos_ext    = CMP_W'(position);
    assign len_ext    = CMP_W'(len_reg);
    assign is_empty   = (len_reg == '0);
    assign is_full    = (len_ext == CMP_W'(DEPTH));

    always_comb begin
        ctl          = '0;
        ctl.val      = push_value;
        status       = ST_OK;
        len_next     = len_reg;
        if (req_type == REQ_PUSH) begin
            if (is_full) begin
                status = ST_FULL;
            end else begin
                ctl.ins  = s_fire;
                len_next = LEN_W'(len_ext + 1'b1);
                priority if (is_empty || position == POS_W'(1)) begin
                    ctl.at = '0;
                end else if (position == '0 || pos_ext > len_ext + 1'b1) begin
                    ctl.at = POS_W'(len_reg);
                end else begin
                    ctl.at = position - 1'b1;
                end
            end
        end else begin
            ctl.at = position - 1'b1;
            priority if (is_empty) begin
                status = ST_EMPTY;
            end else if (position == '0 || pos_ext > len_ext) begin
                status = ST_OOB;
            end else begin
                ctl.del  = s_fire;
                len_next = LEN_W'(len_ext - 1'b1);
            end
        end
    end

    // row of cells, neighbors wired left and right
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;
        if (i == 0) begin : g_head
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_data[i+1];
        end
        plq_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .cell_idx   (POS_W'(i)),
            .left_data  (left_w),
            .right_data (right_w),
            .data_out   (cell_data[i]),
            .hit_data   (cell_hit[i])
        );
    end

    always_comb begin
        hit_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_or = hit_or | cell_hit[i];
        end
    end

    assign popped_value = ctl.del ? hit_or : '0;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, ENTRY_W'(len_next), status, popped_value};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                len_reg <= len_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_ext <= CMP_W'(DEPTH))
        else $error("list length above depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && req_type == REQ_PUSH && !is_full |=> len_reg == LEN_W'($past(len_ext) + 1'b1))
        else $error("accepted push did not grow the list");

    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_tvalid && m_tdata[38:34] == ENTRY_W'(len_reg))
        else $error("reported count differs from list length");

endmodule

FILE: sv/plq_cell.sv
// one list slot: shifts toward the tail on insert, toward the head on delete
`timescale 1ns / 1ps
module plq_cell (
    input  logic                         aclk,
    input  plq_pkg::plq_ctl_t            ctl,
    input  logic [plq_pkg::POS_W-1:0]    cell_idx,
    input  logic [plq_pkg::DATA_W-1:0]   left_data,
    input  logic [plq_pkg::DATA_W-1:0]   right_data,
    output logic [plq_pkg::DATA_W-1:0]   data_out,
    output logic [plq_pkg::DATA_W-1:0]   hit_data
);
    import plq_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        priority if (ctl.ins && cell_idx == ctl.at) begin
            data_next = ctl.val;
        end else if (ctl.ins && cell_idx > ctl.at) begin
            data_next = left_data;
        end else if (ctl.del && cell_idx >= ctl.at) begin
            data_next = right_data;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    // only the addressed cell drives its word onto the or-tree
    assign hit_data = (cell_idx == ctl.at) ? data_reg : '0;

endmodule

FILE: tb/sv/positional_list_queue_test.sv
// self-checking testbench for the positional list queue
`timescale 1ns / 1ps
module positional_list_queue_test;
    import plq_pkg::*;

    localparam int LIST_DEPTH  = 16;
    localparam int HOLD_CYCLES = 60;
    localparam int STALL_LIMIT = 400;

    typedef struct packed {
        logic [DATA_W-1:0]  popped;
        plq_status_t        status;
        logic [ENTRY_W-1:0] count;
    } list_result_t;

    // one directed row, repeated reps times; pinned rows carry a typed-in result
    typedef struct packed {
        logic              req;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        logic [7:0]        reps;
        logic              pinned;
        list_result_t      want;
    } list_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // position [7:0], push_value [39:8]
    logic        s_tuser  = 1'b0; // req_type [0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // popped_value [31:0], status [33:32], entry_count [38:34]

    logic         row_pinned = 1'b0;
    list_result_t row_want   = '0;

    // predicted contents of the list
    logic [DATA_W-1:0] list_words [LIST_DEPTH];
    int                list_len = 0;

    list_result_t expected_results [$];
    int           mismatches    = 0;
    int           idle_cycles   = 0;
    bit           hold_request  = 1'b0;
    bit           no_gaps       = 1'b0;

    list_row_t directed_rows [0:15];

    positional_list_queue #(.DEPTH(LIST_DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic list_result_t apply_request(input logic req,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [DATA_W-1:0] val);
        list_result_t r;
        int p;
        int at;
        int i;
        r = '0;
        r.status = ST_OK;
        p = int'(pos);
        if (req == REQ_PUSH) begin
            if (list_len >= LIST_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                if (list_len == 0 || p == 1)
                    at = 0;
                else if (p == 0 || p - 1 > list_len)
                    at = list_len;
                else
                    at = p - 1;
                for (i = list_len; i > at; i--)
                    list_words[i] = list_words[i-1];
                list_words[at] = val;
                list_len++;
            end
        end else begin
            if (list_len == 0) begin
                r.status = ST_EMPTY;
            end else if (p == 0 || p > list_len) begin
                r.status = ST_OOB;
            end else begin
                at = p - 1;
                r.popped = list_words[at];
                for (i = at; i + 1 < list_len; i++)
                    list_words[i] = list_words[i+1];
                list_len--;
            end
        end
        r.count = ENTRY_W'(list_len);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s got %h want %h", $realtime, field, got, want);
        mismatches++;
    endtask

    // beats on both sides, sampled at the rising edge
    always @(posedge aclk) begin
        list_result_t got;
        list_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.popped = m_tdata[31:0];
                got.status = plq_status_t'(m_tdata[33:32]);
                got.count  = m_tdata[38:34];
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result beat", m_tdata[31:0], '0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.popped !== want.popped)
                        report_mismatch("popped_value", got.popped, want.popped);
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.count !== want.count)
                        report_mismatch("entry_count", 32'(got.count), 32'(want.count));
                end
            end
            if (s_tvalid && s_tready) begin
                want = apply_request(s_tuser, s_tdata[7:0], s_tdata[39:8]);
                if (row_pinned)
                    want = row_want;
                expected_results.push_back(want);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            if (hold_request) begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, 4);
            end
            if (stall > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_request(input logic req, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val, input logic pinned,
                                input list_result_t want);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid   <= 1'b1;
        s_tuser    <= req;
        s_tdata    <= {val, pos};
        row_pinned <= pinned;
        row_want   <= want;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    // stop offering and let every outstanding result drain
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic run_random(input int n, input int push_pct);
        logic              req;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        int                pick;
        for (int k = 0; k < n; k++) begin
            req  = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
            pick = $urandom_range(0, 9);
            // mostly positions within the list, now and then anything
            if (pick < 7)
                pos = POS_W'($urandom_range(0, list_len + 1));
            else if (pick < 8)
                pos = '0;
            else
                pos = POS_W'($urandom_range(0, 255));
            case ($urandom_range(0, 7))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7fff_ffff;
                2:       val = '1;
                3:       val = '0;
                default: val = $urandom();
            endcase
            send_request(req, pos, val, 1'b0, '0);
        end
        drain_results();
    endtask

    initial begin
        directed_rows = '{
            '{REQ_POP,  8'd1,   32'h0000_0000, 8'd1,  1'b1, '{32'd0, ST_EMPTY, 5'd0}},
            '{REQ_PUSH, 8'd5,   32'h7fff_ffff, 8'd1,  1'b1, '{32'd0, ST_OK,    5'd1}},
            '{REQ_PUSH, 8'd0,   32'h8000_0000, 8'd1,  1'b1, '{32'd0, ST_OK,    5'd2}},
            '{REQ_PUSH, 8'd1,   32'hffff_ffff, 8'd1,  1'b1, '{32'd0, ST_OK,    5'd3}},
            '{REQ_PUSH, 8'd2,   32'h1234_5678, 8'd1,  1'b1, '{32'd0, ST_OK,    5'd4}},
            '{REQ_PUSH, 8'd255, 32'ha5a5_a5a5, 8'd1,  1'b1, '{32'd0, ST_OK,    5'd5}},
            '{REQ_PUSH, 8'd6,   32'h5a5a_5a5a, 8'd1,  1'b1, '{32'd0, ST_OK,    5'd6}},
            '{REQ_POP,  8'd0,   32'h0000_0000, 8'd1,  1'b1, '{32'd0, ST_OOB,   5'd6}},
            '{REQ_POP,  8'd7,   32'hdead_beef, 8'd1,  1'b1, '{32'd0, ST_OOB,   5'd6}},
            '{REQ_POP,  8'd1,   32'h0000_0000, 8'd1,  1'b0, '0},
            '{REQ_POP,  8'd5,   32'h0000_0000, 8'd1,  1'b0, '0},
            '{REQ_POP,  8'd2,   32'h0000_0000, 8'd1,  1'b0, '0},
            '{REQ_PUSH, 8'd3,   32'h0f0f_0f0f, 8'd13, 1'b0, '0},
            '{REQ_PUSH, 8'd0,   32'h0bad_f00d, 8'd1,  1'b1, '{32'd0, ST_FULL,  5'd16}},
            '{REQ_POP,  8'd16,  32'h0000_0000, 8'd1,  1'b0, '0},
            '{REQ_POP,  8'd255, 32'h0000_0000, 8'd1,  1'b1, '{32'd0, ST_OOB,   5'd15}}
        };

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r])
            repeat (directed_rows[r].reps)
                send_request(directed_rows[r].req, directed_rows[r].pos, directed_rows[r].val,
                             directed_rows[r].pinned, directed_rows[r].want);
        drain_results();

        run_random(120, 70);
        run_random(100, 25);
        hold_request = 1'b1;   // receiver backs off while the list fills
        run_random(120, 85);
        run_random(100, 20);
        no_gaps = 1'b1;
        run_random(110, 50);

        repeat (4) @(posedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
